FILE: rtl/moving_average_to_pwm_duty_top_macros.svh
// ----------------------------------------------------------------------------
// moving_average_to_pwm_duty_top_macros.svh
// Assertion shorthands for the moving-average PWM duty block checker.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_TO_PWM_DUTY_TOP_MACROS_SVH
`define MOVING_AVERAGE_TO_PWM_DUTY_TOP_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent
`define MAPWM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mapwm check failed");

// Check that the consequent holds in the same cycle as the antecedent
`define MAPWM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mapwm check failed");

`endif

FILE: rtl/mapwm_pkg.sv
// ----------------------------------------------------------------------------
// mapwm_pkg
// Types and constants shared by the moving-average PWM duty block.
// ----------------------------------------------------------------------------
`default_nettype none

package mapwm_pkg;

   // Field widths
   localparam int ADC_W    = 10;
   localparam int SAMPLE_W = 8;
   localparam int OFFSET_W = 8;
   localparam int GAIN_W   = 6;
   localparam int DUTY_W   = 14;

   // Window average never exceeds a sample
   localparam int QUO_W  = SAMPLE_W;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // Register indexes
   localparam logic [0:0] REG_LEVEL_OFFSET = 1'b0;
   localparam logic [0:0] REG_DUTY_GAIN    = 1'b1;

   // Register reset values
   localparam logic [OFFSET_W-1:0] LEVEL_OFFSET_RST = 8'd125;
   localparam logic [GAIN_W-1:0]   DUTY_GAIN_RST    = 6'd48;

   // Item kinds
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_LAST,
      ST_DIV,
      ST_SCALE
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/moving_average_to_pwm_duty_top.sv
// ----------------------------------------------------------------------------
// moving_average_to_pwm_duty_top
// Boxcar average over a ring of converter samples, turned into a PWM duty.
// ----------------------------------------------------------------------------
// A sample item (func 0) puts its top 8 bits into the ring memory and
// advances the write position; the fill count advances until the ring is
// full. A tick item (func 1) before the ring is full gives no result. Once
// full, a tick runs a pass before the next item is taken: the ring memory has
// a single read port, so the sum state walks the entries one per cycle, the
// last state lands the last read, the divide state divides the sum by
// WINDOW_DEPTH through a multiply by its reciprocal, and the scale state
// applies offset and gain into the result register. The result register
// holds a finished item while the next one is accepted; a following tick
// that finishes while it is still held waits in its scale state until the
// result is taken. The ring needs no clearing pass after reset: it is read
// only once every entry was written.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_to_pwm_duty_top #(
   parameter int WINDOW_DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input item channel
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_func,
   input  wire logic [mapwm_pkg::ADC_W-1:0]     req_adc_sample,
   // result item channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [mapwm_pkg::DUTY_W-1:0]    rsp_duty_value,
   // configuration port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [mapwm_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [mapwm_pkg::CSR_DW-1:0]    csr_pwdata,
   output      logic [mapwm_pkg::CSR_DW-1:0]    csr_prdata,
   output      logic                            csr_pready
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = mapwm_pkg::SAMPLE_W + IDX_W;

   // Reciprocal of the window depth, exact for every reachable sum
   localparam int RCP_SH = SUM_W + IDX_W;
   localparam int RCP_W  = SUM_W + 2;
   localparam int PROD_W = SUM_W + RCP_W;
   localparam longint unsigned RCP_VAL =
      ((64'd1 << RCP_SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
   localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

   // Configuration registers
   logic [mapwm_pkg::OFFSET_W-1:0] level_offset_ff;
   logic [mapwm_pkg::GAIN_W-1:0]   duty_gain_ff;
   logic                           csr_wr;
   logic [0:0]                     csr_idx;

   // Sequencer and control state
   mapwm_pkg::state_type           state_ff, state_in;
   logic [IDX_W-1:0]               wr_pos_ff, wr_pos_in;
   logic [CNT_W-1:0]               fill_ff, fill_in;
   logic [IDX_W-1:0]               rd_addr_ff, rd_addr_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Datapath
   logic [mapwm_pkg::SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];
   logic [mapwm_pkg::SAMPLE_W-1:0] mem_q_ff;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [mapwm_pkg::QUO_W-1:0]    quo_ff, quo_in;
   logic [mapwm_pkg::DUTY_W-1:0]   duty_ff, duty_in;

   logic                           req_acc;
   logic                           ring_wr;
   logic                           ring_full;
   logic [PROD_W-1:0]              div_prod;
   logic [mapwm_pkg::SAMPLE_W-1:0] corrected;
   logic                           load_rsp;

   // ------------------------------------------------------------------
   // Configuration port: zero-wait writes, combinational read back
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_offset_ff <= mapwm_pkg::LEVEL_OFFSET_RST;
         duty_gain_ff    <= mapwm_pkg::DUTY_GAIN_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            mapwm_pkg::REG_LEVEL_OFFSET: begin
               level_offset_ff <= csr_pwdata[mapwm_pkg::OFFSET_W-1:0];
            end
            mapwm_pkg::REG_DUTY_GAIN: begin
               duty_gain_ff <= csr_pwdata[mapwm_pkg::GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         mapwm_pkg::REG_LEVEL_OFFSET: begin
            csr_prdata = mapwm_pkg::CSR_DW'(level_offset_ff);
         end
         mapwm_pkg::REG_DUTY_GAIN: begin
            csr_prdata = mapwm_pkg::CSR_DW'(duty_gain_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Ring memory: one write port, one registered read port
   // ------------------------------------------------------------------
   assign req_ready = (state_ff == mapwm_pkg::ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign ring_wr   = req_acc && (req_func == mapwm_pkg::FUNC_SAMPLE);
   assign ring_full = (fill_ff == CNT_W'(WINDOW_DEPTH));

   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring_mem[wr_pos_ff] <= req_adc_sample[mapwm_pkg::ADC_W-1 -: mapwm_pkg::SAMPLE_W];
      end
      mem_q_ff <= ring_mem[rd_addr_ff];
   end

   // ------------------------------------------------------------------
   // Division by the window depth and final scaling
   // ------------------------------------------------------------------
   assign div_prod  = PROD_W'(sum_ff) * PROD_W'(RCP);
   assign corrected = (quo_ff >= level_offset_ff) ? (quo_ff - level_offset_ff) : '0;
   assign duty_in   = mapwm_pkg::DUTY_W'(corrected) * mapwm_pkg::DUTY_W'(duty_gain_ff);
   assign load_rsp  = (state_ff == mapwm_pkg::ST_SCALE) && (!rsp_valid_ff || rsp_ready);

   // ------------------------------------------------------------------
   // Sequencer: next state and next values
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      wr_pos_in    = wr_pos_ff;
      fill_in      = fill_ff;
      rd_addr_in   = rd_addr_ff;
      rd_vld_in    = 1'b0;
      sum_in       = sum_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // accumulate read data in the cycle after its address is presented
      if (rd_vld_ff) begin
         sum_in = sum_ff + SUM_W'(mem_q_ff);
      end

      case (state_ff)
         mapwm_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_func == mapwm_pkg::FUNC_SAMPLE) begin
                  // advance write position, and fill count until the ring is full
                  wr_pos_in = (wr_pos_ff == IDX_W'(WINDOW_DEPTH - 1)) ?
                              '0 : wr_pos_ff + 1'b1;
                  if (!ring_full) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end else if (ring_full) begin
                  // start a sum pass over the ring
                  rd_addr_in = '0;
                  sum_in     = '0;
                  state_in   = mapwm_pkg::ST_SUM;
               end
            end
         end
         mapwm_pkg::ST_SUM: begin
            rd_vld_in = 1'b1;
            if (rd_addr_ff == IDX_W'(WINDOW_DEPTH - 1)) begin
               state_in = mapwm_pkg::ST_LAST;
            end else begin
               rd_addr_in = rd_addr_ff + 1'b1;
            end
         end
         mapwm_pkg::ST_LAST: begin
            // last entry lands this cycle
            state_in = mapwm_pkg::ST_DIV;
         end
         mapwm_pkg::ST_DIV: begin
            // take the truncated average from the reciprocal product
            quo_in   = div_prod[RCP_SH +: mapwm_pkg::QUO_W];
            state_in = mapwm_pkg::ST_SCALE;
         end
         mapwm_pkg::ST_SCALE: begin
            // hold until the result register is free
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = mapwm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mapwm_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mapwm_pkg::ST_IDLE;
         wr_pos_ff    <= '0;
         fill_ff      <= '0;
         rd_addr_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         fill_ff      <= fill_in;
         rd_addr_ff   <= rd_addr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      quo_ff <= quo_in;
      if (load_rsp) begin
         duty_ff <= duty_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty_value = duty_ff;

endmodule

`default_nettype wire

FILE: rtl/mapwm_checker.sv
// ----------------------------------------------------------------------------
// mapwm_checker
// Port-level checks for the moving-average PWM duty block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_to_pwm_duty_top_macros.svh"

module mapwm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_func,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [mapwm_pkg::DUTY_W-1:0]  rsp_duty_value
);

   logic sample_acc;

   assign sample_acc = req_valid && req_ready && (req_func == mapwm_pkg::FUNC_SAMPLE);

   // a stalled result item holds its value
   `MAPWM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_duty_value))

   // a sample item never raises a result
   `MAPWM_ASSERT_NEXT(a_sample_silent, sample_acc, !$rose(rsp_valid))

   // a result appears only at the end of a tick pass, with intake closed
   `MAPWM_ASSERT_SAME(a_rsp_from_pass, $rose(rsp_valid), !$past(req_ready))

   // duty never exceeds full-scale sample times full-scale gain
   `MAPWM_ASSERT_SAME(a_duty_range, rsp_valid, rsp_duty_value <= 14'd16065)

endmodule

bind moving_average_to_pwm_duty_top mapwm_checker u_mapwm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_func       (req_func),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_duty_value (rsp_duty_value)
);

`default_nettype wire
